// File: design/ssd_pkg.sv
// ssd_pkg: shared types, mode codes and segment font for the scan display
// no dependencies; compiled first

package ssd_pkg;

   localparam int NUM_DIGITS = 4;
   localparam int SEG_W      = 7;
   localparam int ADC_W      = 16;
   localparam int BYTE_W     = 8;
   localparam int IDX_W      = 2;

   localparam logic [SEG_W-1:0] SEG_OFF = 7'h00;
   localparam logic [9:0]       ADC_MAX = 10'd1023;

   typedef enum logic [1:0] {
      MODE_SCAN    = 2'd0,
      MODE_BUTTON  = 2'd1,
      MODE_RELEASE = 2'd2,
      MODE_REFRESH = 2'd3
   } mode_type;

   typedef logic [SEG_W-1:0] glyph_type;
   typedef glyph_type [NUM_DIGITS-1:0] digit_row_type;

   // decimal digit to segments a..g, blank for codes above nine
   function automatic glyph_type glyph(input logic [3:0] d);
      glyph_type g;
      unique case (d)
         4'd0:    g = 7'h3F;
         4'd1:    g = 7'h06;
         4'd2:    g = 7'h5B;
         4'd3:    g = 7'h4F;
         4'd4:    g = 7'h66;
         4'd5:    g = 7'h6D;
         4'd6:    g = 7'h7D;
         4'd7:    g = 7'h07;
         4'd8:    g = 7'h7F;
         4'd9:    g = 7'h6F;
         default: g = SEG_OFF;
      endcase
      return g;
   endfunction

endpackage

// File: design/ssd_req_if.sv
// ssd_req_if: valid/ready channel carrying one display event item
// depends on ssd_pkg

interface ssd_req_if;
   logic                          valid;
   logic                          ready;
   ssd_pkg::mode_type             mode;
   logic                          active;
   logic [ssd_pkg::ADC_W-1:0]     adc_value;
   logic [ssd_pkg::BYTE_W-1:0]    limit_value;
   logic [ssd_pkg::BYTE_W-1:0]    conn_mask;
   logic                          button_level;

   modport source (output valid, mode, active, adc_value, limit_value, conn_mask,
                   button_level, input ready);
   modport sink   (input valid, mode, active, adc_value, limit_value, conn_mask,
                   button_level, output ready);
endinterface

// File: design/ssd_rsp_if.sv
// ssd_rsp_if: valid/ready channel carrying the driven segment and digit lines
// depends on ssd_pkg

interface ssd_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [ssd_pkg::SEG_W-1:0]     segments;
   logic [ssd_pkg::NUM_DIGITS-1:0] digit_enable;
   logic                          page;

   modport source (output valid, segments, digit_enable, page, input ready);
   modport sink   (input valid, segments, digit_enable, page, output ready);
endinterface

// File: design/ssd_refresh.sv
// ssd_refresh: builds the four digit glyphs for a buffer refresh
// depends on ssd_pkg; decimal split by constant reciprocals

module ssd_refresh (
   input  logic                        page,
   input  logic [ssd_pkg::ADC_W-1:0]   adc_value,
   input  logic [ssd_pkg::BYTE_W-1:0]  limit_value,
   input  logic [ssd_pkg::BYTE_W-1:0]  conn_mask,
   output ssd_pkg::digit_row_type      digits
);
   import ssd_pkg::*;

   logic [9:0]  sat;
   logic [17:0] prod_ten;
   logic [15:0] prod_hun;
   logic [6:0]  q_ten;
   logic [3:0]  q_hun;
   logic [9:0]  ten_times;
   logic [6:0]  hun_times;
   logic [3:0]  adc_thou;
   logic [3:0]  adc_hund;
   logic [3:0]  adc_tens;
   logic [3:0]  adc_unit;
   logic [15:0] lim_prod;
   logic [4:0]  lim_q;
   logic [7:0]  lim_times;
   logic [3:0]  lim_tens;
   logic [3:0]  lim_unit;

   // saturate, then split by x*205>>11 (x/10) and x*41>>12 (x/100)
   always_comb begin
      sat       = (adc_value > 16'(ADC_MAX)) ? ADC_MAX : adc_value[9:0];
      prod_ten  = 18'(sat) * 18'd205;
      prod_hun  = 16'(sat) * 16'd41;
      q_ten     = prod_ten[17:11];
      q_hun     = prod_hun[15:12];
      ten_times = 10'(q_ten) * 10'd10;
      hun_times = 7'(q_hun) * 7'd10;
      adc_unit  = 4'(sat - ten_times);
      adc_tens  = 4'(q_ten - hun_times);
      adc_hund  = (q_hun >= 4'd10) ? q_hun - 4'd10 : q_hun;
      adc_thou  = {3'b000, (sat >= 10'd1000)};
   end

   always_comb begin
      lim_prod  = 16'(limit_value) * 16'd205;
      lim_q     = lim_prod[15:11];
      lim_times = 8'(lim_q) * 8'd10;
      lim_unit  = 4'(limit_value - lim_times);
      priority if (lim_q >= 5'd20) begin
         lim_tens = 4'(lim_q - 5'd20);
      end else if (lim_q >= 5'd10) begin
         lim_tens = 4'(lim_q - 5'd10);
      end else begin
         lim_tens = 4'(lim_q);
      end
   end

   always_comb begin
      if (page) begin
         digits[0] = glyph(lim_tens);
         digits[1] = glyph(lim_unit);
         digits[2] = SEG_OFF;
         digits[3] = glyph({1'b0, conn_mask[2:0]});
      end else begin
         digits[0] = glyph(adc_thou);
         digits[1] = glyph(adc_hund);
         digits[2] = glyph(adc_tens);
         digits[3] = glyph(adc_unit);
      end
   end

endmodule

// File: design/seven_segment_scan_display.sv
// seven_segment_scan_display: four-digit multiplexed display driver top level
// depends on ssd_pkg, ssd_req_if, ssd_rsp_if, ssd_refresh
//
//   channel   dir   signals                                                  
//   req_bus   in    mode active adc_value limit_value conn_mask button_level  
//   rsp_bus   out   segments digit_enable page (one item per request item)   
//
// one item per cycle sustained while rsp_bus is not stalled; each item passes the input
// register, then the result register that also holds the segment, enable and page lines
// reset (synchronous) blanks the digit store and lines, page 0, button high
// a stalled rsp_bus holds the result; req_bus stays ready while the input
// register can move on in the same cycle

module seven_segment_scan_display (
   input logic        clock,
   input logic        reset,
   ssd_req_if.sink    req_bus,
   ssd_rsp_if.source  rsp_bus
);
   import ssd_pkg::*;

   logic                  s1_valid_ff, s1_valid_in;
   mode_type              mode_ff;
   logic                  active_ff;
   logic [ADC_W-1:0]      adc_ff;
   logic [BYTE_W-1:0]     limit_ff;
   logic [BYTE_W-1:0]     conn_ff;
   logic                  level_ff;

   digit_row_type         store_ff, store_in;
   logic [IDX_W-1:0]      scan_ff, scan_in;
   logic                  page_ff, page_in;
   logic                  pend_ff, pend_in;
   logic                  prev_ff, prev_in;
   glyph_type             seg_ff, seg_in;
   logic [NUM_DIGITS-1:0] en_ff, en_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   logic                  req_fire;
   logic                  rsp_fire;
   logic                  advance;
   digit_row_type         fresh;

   assign advance  = s1_valid_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !s1_valid_ff || advance;
   assign req_fire = req_bus.valid && req_bus.ready;
   assign rsp_fire = rsp_valid_ff && rsp_bus.ready;

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.segments     = seg_ff;
   assign rsp_bus.digit_enable = en_ff;
   assign rsp_bus.page         = page_ff;

   ssd_refresh u_refresh (
      .page        (page_ff),
      .adc_value   (adc_ff),
      .limit_value (limit_ff),
      .conn_mask   (conn_ff),
      .digits      (fresh)
   );

   always_comb begin
      s1_valid_in  = req_fire ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);
      rsp_valid_in = advance ? 1'b1 : (rsp_fire ? 1'b0 : rsp_valid_ff);
   end

   always_comb begin
      store_in = store_ff;
      scan_in  = scan_ff;
      page_in  = page_ff;
      pend_in  = pend_ff;
      prev_in  = prev_ff;
      seg_in   = seg_ff;
      en_in    = en_ff;
      if (advance) begin
         unique case (mode_ff)
            MODE_SCAN: begin
               if (active_ff) begin
                  seg_in  = store_ff[scan_ff];
                  en_in   = NUM_DIGITS'(1) << scan_ff;
                  scan_in = scan_ff + IDX_W'(1);
               end else begin
                  seg_in = SEG_OFF;
                  en_in  = '0;
               end
            end
            MODE_BUTTON: begin
               if (!prev_ff && level_ff) begin
                  pend_in = 1'b1;
               end
               prev_in = level_ff;
            end
            MODE_RELEASE: begin
               pend_in = 1'b0;
               if (active_ff && pend_ff) begin
                  page_in = !page_ff;
               end
            end
            MODE_REFRESH: begin
               if (active_ff) begin
                  store_in = fresh;
               end else begin
                  store_in = '0;
                  seg_in   = SEG_OFF;
                  en_in    = '0;
               end
            end
            default: begin
               store_in = store_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         mode_ff   <= req_bus.mode;
         active_ff <= req_bus.active;
         adc_ff    <= req_bus.adc_value;
         limit_ff  <= req_bus.limit_value;
         conn_ff   <= req_bus.conn_mask;
         level_ff  <= req_bus.button_level;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         store_ff     <= '0;
         scan_ff      <= '0;
         page_ff      <= 1'b0;
         pend_ff      <= 1'b0;
         prev_ff      <= 1'b1;
         seg_ff       <= SEG_OFF;
         en_ff        <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         store_ff     <= store_in;
         scan_ff      <= scan_in;
         page_ff      <= page_in;
         pend_ff      <= pend_in;
         prev_ff      <= prev_in;
         seg_ff       <= seg_in;
         en_ff        <= en_in;
      end
   end

endmodule

// File: design/ssd_checker.sv
// ssd_checker: port-level assertions for the scan display, bound to the top
// depends on ssd_pkg, seven_segment_scan_display

module ssd_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [ssd_pkg::SEG_W-1:0]       segments,
   input logic [ssd_pkg::NUM_DIGITS-1:0]  digit_enable,
   input logic                            page
);
   import ssd_pkg::*;

   // at most one digit driven at a time
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $onehot0(digit_enable))
      else $error("more than one digit enabled");

   // blanked digits never carry lit segments
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (digit_enable == '0)) |-> (segments == SEG_OFF))
      else $error("segments lit while no digit enabled");

   // nothing offered right after reset
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result offered after reset");

   // stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(segments) && $stable(digit_enable) && $stable(page)))
      else $error("stalled result changed");

endmodule

bind seven_segment_scan_display ssd_checker u_ssd_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_bus.valid),
   .rsp_ready    (rsp_bus.ready),
   .segments     (rsp_bus.segments),
   .digit_enable (rsp_bus.digit_enable),
   .page         (rsp_bus.page)
);

// File: verif/tb_seven_segment_scan_display.sv
// tb_seven_segment_scan_display: self-checking bench for the four-digit scan display driver
// predicts segment, digit-enable and page lines per event item and checks each rsp_bus item
// depends on ssd_pkg, ssd_req_if, ssd_rsp_if and seven_segment_scan_display
`timescale 1ns / 1ps

module tb_seven_segment_scan_display;
   import ssd_pkg::*;

   localparam int QUIET_LIMIT   = 600;
   localparam int HOLD_OFF_LEN  = 90;
   localparam int SETTLE_CYCLES = 10;
   localparam int RANDOM_EVENTS = 2000;

   typedef struct {
      mode_type    mode;
      logic        active;
      logic [15:0] adc;
      logic [7:0]  limit;
      logic [7:0]  conn;
      logic        button;
   } display_event_type;

   typedef struct {
      logic [6:0] segments;
      logic [3:0] enable;
      logic       page;
   } display_lines_type;

   logic clock;
   logic reset;

   ssd_req_if req_bus ();
   ssd_rsp_if rsp_bus ();

   seven_segment_scan_display dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   glyph_type      shown_digits [NUM_DIGITS];
   logic [1:0]     next_digit;
   logic           page_now;
   logic           release_armed;
   logic           last_button;
   glyph_type      seg_now;
   logic [3:0]     en_now;

   display_lines_type lines_expected [$];
   display_lines_type line_front;
   int             faults;
   int             events_sent;
   int             burst_left;
   bit             steady_burst;
   bit             hold_off_request;
   int             quiet_cycles;
   int             rsp_cycle;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic glyph_type font_of(int unsigned d);
      case (d)
         0: return 7'h3F;
         1: return 7'h06;
         2: return 7'h5B;
         3: return 7'h4F;
         4: return 7'h66;
         5: return 7'h6D;
         6: return 7'h7D;
         7: return 7'h07;
         8: return 7'h7F;
         default: return 7'h6F;
      endcase
   endfunction

   function void predict_lines(input display_event_type ev);
      int unsigned    shown;
      display_lines_type r;
      case (ev.mode)
         MODE_SCAN: begin
            en_now = 4'b0000;
            if (!ev.active) begin
               seg_now = SEG_OFF;
            end else begin
               seg_now    = shown_digits[next_digit];
               en_now     = 4'b0001 << next_digit;
               next_digit = next_digit + 2'd1;
            end
         end
         MODE_BUTTON: begin
            if (!last_button && ev.button) release_armed = 1'b1;
            last_button = ev.button;
         end
         MODE_RELEASE: begin
            if (!ev.active) begin
               release_armed = 1'b0;
            end else if (release_armed) begin
               release_armed = 1'b0;
               page_now      = ~page_now;
            end
         end
         default: begin
            if (!ev.active) begin
               for (int i = 0; i < NUM_DIGITS; i++) shown_digits[i] = SEG_OFF;
               seg_now = SEG_OFF;
               en_now  = 4'b0000;
            end else if (!page_now) begin
               shown = (ev.adc > 16'd1023) ? 1023 : ev.adc;
               shown_digits[0] = font_of((shown / 1000) % 10);
               shown_digits[1] = font_of((shown / 100) % 10);
               shown_digits[2] = font_of((shown / 10) % 10);
               shown_digits[3] = font_of(shown % 10);
            end else begin
               shown_digits[0] = font_of((ev.limit / 10) % 10);
               shown_digits[1] = font_of(ev.limit % 10);
               shown_digits[2] = SEG_OFF;
               shown_digits[3] = font_of(32'(ev.conn & 8'd7));
            end
         end
      endcase
      r.segments = seg_now;
      r.enable   = en_now;
      r.page     = page_now;
      lines_expected.push_back(r);
   endfunction

   function automatic display_event_type build_event(mode_type m, logic act, logic [15:0] adc,
                                                     logic [7:0] lim, logic [7:0] conn,
                                                     logic btn);
      display_event_type ev;
      ev.mode   = m;
      ev.active = act;
      ev.adc    = adc;
      ev.limit  = lim;
      ev.conn   = conn;
      ev.button = btn;
      return ev;
   endfunction

   function automatic display_event_type random_event(mode_type m, logic act);
      logic [15:0] adc;
      adc = ($urandom_range(0, 1) != 0) ? 16'($urandom_range(0, 1100)) : 16'($urandom);
      return build_event(m, act, adc, 8'($urandom), 8'($urandom), 1'($urandom));
   endfunction

   function automatic logic mostly_active();
      return ($urandom_range(0, 15) != 0);
   endfunction

   task automatic send_event(input display_event_type ev);
      int gap;
      if (!steady_burst && burst_left == 0) begin
         gap        = $urandom_range(0, 6);
         burst_left = $urandom_range(1, 40);
         if (gap != 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      if (burst_left > 0) burst_left--;
      req_bus.valid        <= 1'b1;
      req_bus.mode         <= ev.mode;
      req_bus.active       <= ev.active;
      req_bus.adc_value    <= ev.adc;
      req_bus.limit_value  <= ev.limit;
      req_bus.conn_mask    <= ev.conn;
      req_bus.button_level <= ev.button;
      do @(posedge clock); while (!req_bus.ready);
      predict_lines(ev);
      events_sent++;
   endtask

   task automatic wait_for_drain();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (lines_expected.size() != 0);
   endtask

   task automatic send_scans(int count, logic act);
      for (int i = 0; i < count; i++) send_event(random_event(MODE_SCAN, act));
   endtask

   task automatic test_blank_start();
      // store is blank after reset, an active scan still enables a digit, an inactive one blanks
      send_event(build_event(MODE_SCAN, 1'b1, 16'h0000, 8'h00, 8'h00, 1'b1));
      send_event(build_event(MODE_SCAN, 1'b0, 16'hFFFF, 8'hFF, 8'hFF, 1'b0));
   endtask

   task automatic test_converter_page();
      // saturation above 1023, then zero
      send_event(build_event(MODE_REFRESH, 1'b1, 16'hFFFF, 8'h00, 8'h00, 1'b1));
      send_scans(4, 1'b1);
      send_event(build_event(MODE_REFRESH, 1'b1, 16'd1024, 8'h00, 8'h00, 1'b1));
      send_event(build_event(MODE_REFRESH, 1'b1, 16'd0, 8'hFF, 8'hFF, 1'b0));
      send_scans(1, 1'b1);
   endtask

   task automatic test_page_toggle();
      // button starts high so the first high sample is no edge
      send_event(build_event(MODE_BUTTON, 1'b1, 16'h0000, 8'h00, 8'h00, 1'b1));
      send_event(build_event(MODE_BUTTON, 1'b1, 16'h0000, 8'h00, 8'h00, 1'b0));
      send_event(build_event(MODE_BUTTON, 1'b1, 16'h0000, 8'h00, 8'h00, 1'b1));
      send_event(build_event(MODE_RELEASE, 1'b1, 16'h0000, 8'h00, 8'h00, 1'b0));
      send_event(build_event(MODE_RELEASE, 1'b1, 16'h0000, 8'h00, 8'h00, 1'b0));
      send_event(build_event(MODE_REFRESH, 1'b1, 16'hFFFF, 8'd255, 8'hFF, 1'b0));
      send_scans(4, 1'b1);
   endtask

   task automatic test_inactive_unit();
      // edge still seen while inactive, then release while inactive drops it
      send_event(build_event(MODE_BUTTON, 1'b0, 16'h0000, 8'h00, 8'h00, 1'b0));
      send_event(build_event(MODE_BUTTON, 1'b0, 16'h0000, 8'h00, 8'h00, 1'b1));
      send_event(build_event(MODE_RELEASE, 1'b0, 16'h0000, 8'h00, 8'h00, 1'b1));
      send_event(build_event(MODE_RELEASE, 1'b1, 16'h0000, 8'h00, 8'h00, 1'b1));
      send_event(build_event(MODE_REFRESH, 1'b0, 16'd999, 8'd99, 8'h07, 1'b1));
      send_scans(1, 1'b0);
      send_scans(1, 1'b1);
   endtask

   task automatic test_backpressure();
      hold_off_request = 1'b1;
      steady_burst     = 1'b1;
      for (int i = 0; i < 40; i++) begin
         send_event(random_event(mode_type'($urandom_range(0, 3)), mostly_active()));
      end
      steady_burst = 1'b0;
   endtask

   task automatic test_drain_pause();
      wait_for_drain();
      send_event(random_event(MODE_REFRESH, 1'b1));
      send_scans(4, 1'b1);
   endtask

   task automatic test_random_traffic();
      int target;
      int kind;
      target = events_sent + RANDOM_EVENTS;
      while (events_sent < target) begin
         kind = $urandom_range(0, 19);
         if (kind < 6) begin
            send_event(random_event(MODE_REFRESH, mostly_active()));
            for (int i = $urandom_range(3, 8); i > 0; i--) begin
               send_event(random_event(MODE_SCAN, mostly_active()));
            end
         end else if (kind < 10) begin
            send_event(build_event(MODE_BUTTON, mostly_active(), 16'($urandom),
                                   8'($urandom), 8'($urandom), 1'b0));
            send_event(build_event(MODE_BUTTON, mostly_active(), 16'($urandom),
                                   8'($urandom), 8'($urandom), 1'b1));
            send_event(random_event(MODE_RELEASE, mostly_active()));
            send_event(random_event(MODE_REFRESH, mostly_active()));
            send_scans(4, 1'b1);
         end else if (kind < 13) begin
            for (int i = $urandom_range(1, 4); i > 0; i--) begin
               send_event(random_event(MODE_BUTTON, 1'($urandom)));
            end
            send_event(random_event(MODE_RELEASE, mostly_active()));
         end else if (kind < 19) begin
            for (int i = $urandom_range(1, 5); i > 0; i--) begin
               send_event(random_event(mode_type'($urandom_range(0, 3)),
                                       ($urandom_range(0, 3) != 0)));
            end
         end else begin
            wait_for_drain();
         end
      end
   endtask

   function void report_fault(input string what, input display_lines_type exp);
      faults++;
      if (faults <= 10) begin
         $display("[%0t] %s: expected seg=%h en=%b page=%b, got seg=%h en=%b page=%b",
                  $realtime, what, exp.segments, exp.enable, exp.page,
                  rsp_bus.segments, rsp_bus.digit_enable, rsp_bus.page);
      end
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (lines_expected.size() == 0) begin
            line_front = '{default: '0};
            report_fault("unexpected item", line_front);
         end else begin
            line_front = lines_expected.pop_front();
            if (rsp_bus.segments !== line_front.segments ||
                rsp_bus.digit_enable !== line_front.enable ||
                rsp_bus.page !== line_front.page) begin
               report_fault("line mismatch", line_front);
            end
         end
      end
   end

   // receiver pattern: free-running, random, sparse, periodic, plus one long hold-off
   initial begin
      rsp_cycle = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_cycle++;
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_OFF_LEN) @(posedge clock);
         end else begin
            case ((rsp_cycle / 128) % 4)
               0: rsp_bus.ready <= 1'b1;
               1: rsp_bus.ready <= ($urandom_range(0, 3) != 0);
               2: rsp_bus.ready <= ($urandom_range(0, 9) < 3);
               default: rsp_bus.ready <= (rsp_cycle % 5 != 0);
            endcase
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      for (int i = 0; i < NUM_DIGITS; i++) shown_digits[i] = SEG_OFF;
      next_digit       = 2'd0;
      page_now         = 1'b0;
      release_armed    = 1'b0;
      last_button      = 1'b1;
      seg_now          = SEG_OFF;
      en_now           = 4'b0000;
      faults           = 0;
      events_sent      = 0;
      burst_left       = 0;
      steady_burst     = 1'b0;
      hold_off_request = 1'b0;

      reset                <= 1'b1;
      req_bus.valid        <= 1'b0;
      req_bus.mode         <= MODE_SCAN;
      req_bus.active       <= 1'b0;
      req_bus.adc_value    <= '0;
      req_bus.limit_value  <= '0;
      req_bus.conn_mask    <= '0;
      req_bus.button_level <= 1'b1;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      test_blank_start();
      test_converter_page();
      test_page_toggle();
      test_inactive_unit();
      test_backpressure();
      test_drain_pause();
      test_random_traffic();

      wait_for_drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (faults == 0 && lines_expected.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// File: seven_segment_scan_display.f
design/ssd_pkg.sv
design/ssd_req_if.sv
design/ssd_rsp_if.sv
design/ssd_refresh.sv
design/seven_segment_scan_display.sv
design/ssd_checker.sv
verif/tb_seven_segment_scan_display.sv
